@@ hdl/assert_macros.svh @@
// Assertion macros shared by the deque modules; they expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition is never true outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ hdl/bdq_pkg.sv @@
// Shared types and codes for the bounded deque with search.
package bdq_pkg;

    localparam int OP_W   = 3;
    localparam int KEY_W  = 32;
    localparam int ST_W   = 2;
    localparam int POS_W  = 4;
    localparam int FILL_W = 5;

    // Request codes
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_SEARCH     = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR      = 3'd5;

    // Result status codes
    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;   // latch the accepted request
        logic exec;      // run the first step of the request
        logic pop_done;  // finish a pop with the read data
        logic scan;      // compare one entry of a search
        logic load;      // load the result register
    } bdq_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic need_read;  // request needs a memory read
        logic is_search;  // request is a search
        logic hit;        // scanned entry equals the key
        logic last;       // scanned entry is the back entry
    } bdq_stat_t;

endpackage

@@ hdl/bdq_if.sv @@
// Request and result channel interfaces of the deque.
interface bdq_req_if;
    logic                               valid;
    logic                               ready;
    logic [bdq_pkg::OP_W-1:0]           op;
    logic signed [bdq_pkg::KEY_W-1:0]   key;

    modport source (output valid, output op, output key, input ready);
    modport sink   (input valid, input op, input key, output ready);
endinterface

interface bdq_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [bdq_pkg::ST_W-1:0]           status;
    logic [bdq_pkg::POS_W-1:0]          position;
    logic signed [bdq_pkg::KEY_W-1:0]   key_out;
    logic [bdq_pkg::FILL_W-1:0]         fill_count;

    modport source (output valid, output status, output position, output key_out,
                    output fill_count, input ready);
    modport sink   (input valid, input status, input position, input key_out,
                    input fill_count, output ready);
endinterface

@@ hdl/bdq_datapath.sv @@
// Datapath of the deque: ring memory, pointers, scan counter and result register.
`include "assert_macros.svh"

module bdq_datapath #(
    parameter int DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bdq_pkg::bdq_cmd_t                   cmd,
    output bdq_pkg::bdq_stat_t                  stat,
    input  logic [bdq_pkg::OP_W-1:0]            in_op,
    input  logic signed [bdq_pkg::KEY_W-1:0]    in_key,
    output logic [bdq_pkg::ST_W-1:0]            status,
    output logic [bdq_pkg::POS_W-1:0]           position,
    output logic signed [bdq_pkg::KEY_W-1:0]    key_out,
    output logic [bdq_pkg::FILL_W-1:0]          fill_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [AW:0]   DEPTH_W  = (AW+1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

    // Ring memory
    logic signed [bdq_pkg::KEY_W-1:0] mem [DEPTH];

    logic [bdq_pkg::OP_W-1:0]         op_reg;
    logic signed [bdq_pkg::KEY_W-1:0] key_reg;
    logic signed [bdq_pkg::KEY_W-1:0] rd_data_reg;
    logic [AW-1:0]                    front_reg, front_next;
    logic [CW-1:0]                    count_reg, count_next;
    logic [AW-1:0]                    idx_reg, idx_next;
    logic [AW-1:0]                    scan_addr_reg, scan_addr_next;

    logic [bdq_pkg::ST_W-1:0]         status_reg, status_next;
    logic [bdq_pkg::POS_W-1:0]        pos_reg, pos_next;
    logic signed [bdq_pkg::KEY_W-1:0] kout_reg, kout_next;
    logic [bdq_pkg::FILL_W-1:0]       fill_reg;

    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic          full, empty;
    logic [AW-1:0] front_dec, front_inc, scan_inc;
    logic [CW-1:0] cnt_m1;
    logic [AW:0]   back_sum, tail_sum;
    logic [AW:0]   back_wrap, tail_wrap;
    logic [AW-1:0] back_addr, tail_addr;
    logic [CW+4:0] fill_ext;
    logic [AW+3:0] pos_ext;

    // Ring arithmetic
    assign full      = (count_reg == DEPTH_C);
    assign empty     = (count_reg == '0);
    assign front_dec = (front_reg == '0) ? LAST_IDX : front_reg - AW'(1);
    assign front_inc = (front_reg == LAST_IDX) ? '0 : front_reg + AW'(1);
    assign scan_inc  = (scan_addr_reg == LAST_IDX) ? '0 : scan_addr_reg + AW'(1);
    assign cnt_m1    = count_reg - CW'(1);
    assign back_sum  = {1'b0, front_reg} + (AW+1)'(count_reg);
    assign tail_sum  = {1'b0, front_reg} + (AW+1)'(cnt_m1);
    assign back_wrap = back_sum - DEPTH_W;
    assign tail_wrap = tail_sum - DEPTH_W;
    assign back_addr = (back_sum >= DEPTH_W) ? back_wrap[AW-1:0] : back_sum[AW-1:0];
    assign tail_addr = (tail_sum >= DEPTH_W) ? tail_wrap[AW-1:0] : tail_sum[AW-1:0];

    // Status to the controller
    assign stat.is_search = (op_reg == bdq_pkg::OP_SEARCH);
    assign stat.need_read = !empty && ((op_reg == bdq_pkg::OP_POP_FRONT) ||
                                       (op_reg == bdq_pkg::OP_POP_BACK) ||
                                       (op_reg == bdq_pkg::OP_SEARCH));
    assign stat.hit  = (rd_data_reg == key_reg);
    assign stat.last = ((CW'(idx_reg) + CW'(1)) == count_reg);

    // Decode the step for this cycle
    always_comb
    begin
        front_next     = front_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        scan_addr_next = scan_addr_reg;
        wr_en          = 1'b0;
        wr_addr        = front_reg;
        rd_en          = 1'b0;
        rd_addr        = front_reg;
        status_next    = bdq_pkg::ST_OK;
        pos_next       = '0;
        kout_next      = '0;

        if (cmd.exec)
        begin
            case (op_reg)
                bdq_pkg::OP_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        status_next = bdq_pkg::ST_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = front_dec;
                        front_next = front_dec;
                        count_next = count_reg + CW'(1);
                    end
                end
                bdq_pkg::OP_PUSH_BACK:
                begin
                    if (full)
                    begin
                        status_next = bdq_pkg::ST_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = back_addr;
                        count_next = count_reg + CW'(1);
                    end
                end
                bdq_pkg::OP_POP_FRONT:
                begin
                    status_next = empty ? bdq_pkg::ST_EMPTY : bdq_pkg::ST_OK;
                    rd_en       = !empty;
                    rd_addr     = front_reg;
                end
                bdq_pkg::OP_POP_BACK:
                begin
                    status_next = empty ? bdq_pkg::ST_EMPTY : bdq_pkg::ST_OK;
                    rd_en       = !empty;
                    rd_addr     = tail_addr;
                end
                bdq_pkg::OP_SEARCH:
                begin
                    status_next    = bdq_pkg::ST_NOT_FOUND;
                    rd_en          = !empty;
                    rd_addr        = front_reg;
                    idx_next       = '0;
                    scan_addr_next = front_inc;
                end
                bdq_pkg::OP_CLEAR:
                begin
                    front_next = '0;
                    count_next = '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.pop_done)
        begin
            // Drop the entry that was read
            kout_next  = rd_data_reg;
            count_next = cnt_m1;
            if (op_reg == bdq_pkg::OP_POP_FRONT)
            begin
                front_next = front_inc;
            end
        end
        else if (cmd.scan)
        begin
            if (stat.hit)
            begin
                pos_next  = pos_ext[bdq_pkg::POS_W-1:0];
                kout_next = key_reg;
            end
            else if (stat.last)
            begin
                status_next = bdq_pkg::ST_NOT_FOUND;
            end
            else
            begin
                // Advance to the next entry
                rd_en          = 1'b1;
                rd_addr        = scan_addr_reg;
                scan_addr_next = scan_inc;
                idx_next       = idx_reg + AW'(1);
            end
        end
    end

    assign fill_ext = {5'b0, count_next};
    assign pos_ext  = {4'b0, idx_reg};

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    // Request, scan and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= in_op;
            key_reg <= in_key;
        end
        idx_reg       <= idx_next;
        scan_addr_reg <= scan_addr_next;
        if (cmd.load)
        begin
            status_reg <= status_next;
            pos_reg    <= pos_next;
            kout_reg   <= kout_next;
            fill_reg   <= fill_ext[bdq_pkg::FILL_W-1:0];
        end
    end

    // Memory with registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= key_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign status     = status_reg;
    assign position   = pos_reg;
    assign key_out    = kout_reg;
    assign fill_count = fill_reg;

    `ASSERT_NEVER(a_count_bound, count_reg > DEPTH_C, "fill count above depth")
    `ASSERT_CLK(a_scan_in_range, cmd.scan |-> (CW'(idx_reg) < count_reg), "scan past back entry")

endmodule

@@ hdl/bdq_ctrl.sv @@
// Controller of the deque: request sequencing and result valid.
`include "assert_macros.svh"

module bdq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  bdq_pkg::bdq_stat_t  stat,
    output bdq_pkg::bdq_cmd_t   cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_POP  = 4'b0100,
        S_SCAN = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // Hold until the result register can take a result
                if (out_free)
                begin
                    cmd.exec = 1'b1;
                    if (stat.need_read)
                    begin
                        state_next = stat.is_search ? S_SCAN : S_POP;
                    end
                    else
                    begin
                        cmd.load   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_POP:
            begin
                cmd.pop_done = 1'b1;
                cmd.load     = 1'b1;
                state_next   = S_IDLE;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.hit || stat.last)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result valid: set on load, drop when the item is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `ASSERT_NEVER(a_no_overwrite, cmd.load && out_valid_reg && !out_ready, "result overwritten")
    `ASSERT_CLK(a_drop_on_take, $fell(out_valid_reg) |-> $past(out_ready), "result dropped")

endmodule

@@ hdl/bounded_deque_with_search_unit.sv @@
// Top level of the bounded deque with linear search.
//
// Usage: requests enter on req (op, key) and every request yields exactly one
// result on rsp (status, position, key_out, fill_count), in request order.
// Both channels move an item at a clock edge where valid and ready are high.
// Push, clear, unused codes and requests on an empty or full store load their
// result in the execute step; a pop reads the entry there and loads it in the
// pop step; a search reads the front entry, then compares one entry per scan
// step until a match or the back entry. A new request is taken the cycle after
// the previous one loads its result; a search is paced by the single memory
// read port, which delivers one stored entry per cycle to the comparator.
// The result register separates the channels: a request is accepted while a
// result still waits, and its work holds before its first step until rsp
// takes the waiting item.
// Reset (rst_n low) empties the deque and drops any waiting result; the
// entry memory is not cleared, so the block is ready once reset is released.
module bounded_deque_with_search_unit #(
    parameter int DEPTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    bdq_req_if.sink   req,
    bdq_rsp_if.source rsp
);

    bdq_pkg::bdq_cmd_t  cmd;
    bdq_pkg::bdq_stat_t stat;

    bdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bdq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_op      (req.op),
        .in_key     (req.key),
        .status     (rsp.status),
        .position   (rsp.position),
        .key_out    (rsp.key_out),
        .fill_count (rsp.fill_count)
    );

endmodule
